[rtl/sseg_pkg.sv]
// shared types, constants and the digit decoder for the seven-segment scan shifter
package sseg_pkg;

    localparam int DIVIDE_W = 16;
    localparam int DIGIT_W = 4;
    localparam int SEL_W = 2;
    localparam int NUM_DIGITS = 4;
    localparam int SCAN_BITS = 16;
    localparam int BIT_CNT_W = 5;

    localparam logic [DIVIDE_W-1:0] DIVIDE_RESET = 16'd20;

    // input kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PUSH = 1'b1;

    // output kinds
    localparam logic ACT_SHIFT = 1'b0;
    localparam logic ACT_LATCH = 1'b1;

    // bit counter value of the latch pulse, right after the sixteen shift items
    localparam logic [BIT_CNT_W-1:0] LATCH_SLOT = 5'd16;

    typedef logic [7:0] seg_code_t;

    localparam seg_code_t STORE_INIT [NUM_DIGITS] = '{8'h41, 8'h3b, 8'h6b, 8'h4d};

    // one scan: digit select byte, then segment byte, both sent msb first
    typedef struct packed {
        logic [7:0] select;
        seg_code_t  segments;
    } scan_word_t;

    function automatic seg_code_t seg_decode(input logic [DIGIT_W-1:0] value);
        seg_code_t code;
        unique case (value)
            4'd0:    code = 8'h11;
            4'd1:    code = 8'h7d;
            4'd2:    code = 8'h23;
            4'd3:    code = 8'h29;
            4'd4:    code = 8'h4d;
            4'd5:    code = 8'h89;
            4'd6:    code = 8'h81;
            4'd7:    code = 8'h3d;
            4'd8:    code = 8'h01;
            default: code = 8'h09;
        endcase
        return code;
    endfunction

endpackage

[rtl/sseg_front.sv]
// front end: prescaler, digit buffer, scan issue into the queue
module sseg_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sseg_pkg::DIVIDE_W-1:0]  cfg_data,
    input  logic                           item_valid,
    input  logic                           item_op,
    input  logic [sseg_pkg::DIGIT_W-1:0]   item_digit,
    output logic                           push_valid,
    output sseg_pkg::scan_word_t           push_word
);
    import sseg_pkg::*;

    logic [DIVIDE_W-1:0] tick_divide_reg;
    logic [DIVIDE_W-1:0] tick_count_reg;
    logic [DIVIDE_W-1:0] tick_count_next;
    logic [SEL_W-1:0]    scan_digit_reg;
    seg_code_t           store_reg [NUM_DIGITS];
    logic                is_tick;
    logic                is_push;
    logic                hit;

    assign cfg_ready = 1'b1;
    assign is_tick = item_valid && (item_op == OP_TICK);
    assign is_push = item_valid && (item_op == OP_PUSH);
    assign tick_count_next = tick_count_reg + 16'd1;
    assign hit = is_tick && (tick_count_next == tick_divide_reg);

    assign push_valid = hit;
    assign push_word.select = 8'b1 << scan_digit_reg;
    assign push_word.segments = store_reg[scan_digit_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_divide_reg <= DIVIDE_RESET;
        end
        else if (cfg_valid)
        begin
            tick_divide_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            scan_digit_reg <= '0;
        end
        else if (hit)
        begin
            tick_count_reg <= '0;
            scan_digit_reg <= scan_digit_reg + 2'd1;
        end
        else if (is_tick)
        begin
            tick_count_reg <= tick_count_next;
        end
    end

    // push shifts the buffer toward entry 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= STORE_INIT;
        end
        else if (is_push)
        begin
            store_reg[0] <= store_reg[1];
            store_reg[1] <= store_reg[2];
            store_reg[2] <= store_reg[3];
            store_reg[3] <= seg_decode(item_digit);
        end
    end

endmodule

[rtl/sseg_queue.sv]
// short fifo of pending scans between front and back
module sseg_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    input  sseg_pkg::scan_word_t push_word,
    output logic                 full,
    input  logic                 pop,
    output logic                 pop_valid,
    output sseg_pkg::scan_word_t pop_word
);
    import sseg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    scan_word_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop_word = entry_reg[rd_ptr_reg];
    assign do_push = push_valid && !full;
    assign do_pop = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push_valid)
        else $error("scan issued into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> pop_valid)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

endmodule

[rtl/sseg_back.sv]
// back end: serializes one scan into 16 shift items and one latch item
module sseg_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  sseg_pkg::scan_word_t q_word,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);
    import sseg_pkg::*;

    logic                   busy_reg;
    logic [SCAN_BITS-1:0]   word_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic                   out_valid_reg;
    logic                   out_bit_reg;
    logic                   out_latch_reg;
    logic                   out_free;
    logic                   emit;
    logic [SCAN_BITS-1:0]   src_word;
    logic                   at_latch;

    assign out_free = !out_valid_reg || m_tready;
    assign emit = out_free && (busy_reg || q_valid);
    assign src_word = busy_reg ? word_reg : q_word;
    assign at_latch = busy_reg && (bit_cnt_reg == LATCH_SLOT);
    // first bit goes out straight from the queue head
    assign q_pop = emit && !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else if (emit)
        begin
            if (!busy_reg)
            begin
                busy_reg <= 1'b1;
                bit_cnt_reg <= 5'd1;
            end
            else if (at_latch)
            begin
                busy_reg <= 1'b0;
                bit_cnt_reg <= '0;
            end
            else
            begin
                bit_cnt_reg <= bit_cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            word_reg <= {src_word[SCAN_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_bit_reg <= at_latch ? 1'b0 : src_word[SCAN_BITS-1];
            out_latch_reg <= at_latch ? ACT_LATCH : ACT_SHIFT;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {7'd0, out_bit_reg};
    assign m_tuser = out_latch_reg;
    assign m_tlast = (out_latch_reg == ACT_LATCH);

    a_latch_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && at_latch) |=> !busy_reg)
        else $error("serializer still busy after latch");

    a_cnt_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (bit_cnt_reg == '0))
        else $error("bit counter nonzero while idle");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg <= LATCH_SLOT)
        else $error("bit counter past latch slot");

endmodule

[rtl/seven_segment_scan_shifter_unit.sv]
// top level of the seven-segment scan shifter
// Drives a four-digit multiplexed seven-segment display through serial shift
// registers. An input item with tuser 0 is a timer tick; one with tuser 1 pushes
// the digit in tdata[3:0] into the four-digit buffer. Every tick_divide ticks a
// scan is queued and later sent as 17 output items: the one-hot digit select
// byte and the segment byte, msb first (tuser 0, bit in tdata[0]), then one
// latch item (tuser 1, tlast 1). The input side takes one item per cycle as
// long as the scan queue (QUEUE_DEPTH entries) has room; the serializer sends
// one output item per cycle while m_tready is high; the input stalls only when
// the queue is full, because ticks issue scans faster than the output drains them.
module seven_segment_scan_shifter_unit
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sseg_pkg::DIVIDE_W-1:0]  cfg_data,     // tick_divide
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,      // [3:0] digit_value
    input  logic                           s_tuser,      // [0] operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,      // [0] serial_bit
    output logic                           m_tlast,      // last_of_scan
    output logic                           m_tuser       // [0] pin_action
);
    import sseg_pkg::*;

    logic       q_full;
    logic       push_valid;
    scan_word_t push_word;
    logic       q_pop;
    logic       q_valid;
    scan_word_t q_word;
    logic       in_accept;

    assign s_tready = !q_full;
    assign in_accept = s_tvalid && s_tready;

    sseg_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .item_valid (in_accept),
        .item_op    (s_tuser),
        .item_digit (s_tdata[DIGIT_W-1:0]),
        .push_valid (push_valid),
        .push_word  (push_word)
    );

    sseg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_word  (push_word),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_word   (q_word)
    );

    sseg_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_word   (q_word),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
